FILE: hw/rtl/period_capture_rpm_meter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the period capture rpm meter
// Short forms for the clocked checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PERIOD_CAPTURE_RPM_METER_MACROS_SVH
`define PERIOD_CAPTURE_RPM_METER_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define PCRM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, masked while reset is low.
`define PCRM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Next-cycle implication that also runs during reset.
`define PCRM_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/pcrm_pkg.sv
// ----------------------------------------------------------------------------
// pcrm_pkg
// Shared types and constants of the period capture rpm meter.
// ----------------------------------------------------------------------------
package pcrm_pkg;

    localparam int unsigned PERIOD_W   = 32;
    localparam int unsigned CAPTURE_W  = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned QUEUE_DEPTH = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_DIVISOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE    = 2'd2;

    // Register reset values
    localparam logic [31:0] CLOCK_HZ_RESET     = 32'd168000000;
    localparam logic [15:0] FREQ_DIVISOR_RESET = 16'd100;
    localparam logic [7:0]  RPM_SCALE_RESET    = 8'd20;

    // Measured period handed from the front to the back
    typedef struct packed {
        logic                valid;
        logic [PERIOD_W-1:0] period;
    } period_item_t;

    // Divider request and response
    typedef struct packed {
        logic                start;
        logic [PERIOD_W-1:0] dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [PERIOD_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: hw/rtl/pcrm_queue.sv
// ----------------------------------------------------------------------------
// pcrm_queue
// Short first-in first-out queue of measured periods.
// ----------------------------------------------------------------------------
module pcrm_queue
    import pcrm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  period_item_t        push,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output logic [PERIOD_W-1:0] head
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [PERIOD_W-1:0] slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = do_push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push.period;
        end
    end

endmodule

FILE: hw/rtl/pcrm_div.sv
// ----------------------------------------------------------------------------
// pcrm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcrm_div
    import pcrm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int unsigned STEP_W = $clog2(PERIOD_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [PERIOD_W-1:0] quo_reg, quo_next;
    logic [PERIOD_W-1:0] dvs_reg, dvs_next;
    logic [PERIOD_W:0]   trial;
    logic                fits;

    assign trial = {rem_reg, quo_reg[PERIOD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next  = fits ? PERIOD_W'(trial - {1'b0, dvs_reg}) : trial[PERIOD_W-1:0];
            quo_next  = {quo_reg[PERIOD_W-2:0], fits};
            step_next = STEP_W'(step_reg + 1'b1);
            if (step_reg == STEP_W'(PERIOD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: hw/rtl/pcrm_front.sv
// ----------------------------------------------------------------------------
// pcrm_front
// Edge phase tracking, overflow counting and period forming.
// ----------------------------------------------------------------------------
module pcrm_front
    import pcrm_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH  = 16,
    parameter int unsigned OVERFLOW_WIDTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CAPTURE_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 queue_full,
    output period_item_t         push
);

    // Only the counter bits that exist in the captured value are kept.
    localparam int unsigned CAP_W = (COUNTER_WIDTH < CAPTURE_W) ? COUNTER_WIDTH : CAPTURE_W;

    logic                      pending_reg, pending_next;
    logic [CAP_W-1:0]          first_reg, first_next;
    logic [OVERFLOW_WIDTH-1:0] ovf_reg, ovf_next;
    logic                      accept;
    logic [CAP_W-1:0]          cap;
    logic [PERIOD_W-1:0]       period;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign cap      = s_tdata[CAP_W-1:0];

    assign period = PERIOD_W'(64'(ovf_reg) << COUNTER_WIDTH)
                  + PERIOD_W'(cap) - PERIOD_W'(first_reg);

    always_comb begin
        pending_next = pending_reg;
        first_next   = first_reg;
        ovf_next     = ovf_reg;
        push.valid   = 1'b0;
        push.period  = period;
        if (accept) begin
            if (!s_tuser) begin
                if (pending_reg && !(&ovf_reg)) begin
                    ovf_next = OVERFLOW_WIDTH'(ovf_reg + 1'b1);
                end
            end else if (!pending_reg) begin
                first_next   = cap;
                ovf_next     = '0;
                pending_next = 1'b1;
            end else begin
                ovf_next     = '0;
                pending_next = 1'b0;
                push.valid   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            first_reg   <= '0;
            ovf_reg     <= '0;
        end else begin
            pending_reg <= pending_next;
            first_reg   <= first_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

FILE: hw/rtl/pcrm_back.sv
// ----------------------------------------------------------------------------
// pcrm_back
// Frequency and rpm evaluation of queued periods, result register.
// ----------------------------------------------------------------------------
module pcrm_back
    import pcrm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  queue_empty,
    input  logic [PERIOD_W-1:0]   queue_head,
    output logic                  queue_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [3*PERIOD_W-1:0] m_tdata,
    output logic                  m_tuser
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV1 = 5'b00010,
        ST_DIV2 = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] clock_hz_reg;
    logic [15:0] freq_div_reg;
    logic [7:0]  rpm_scale_reg;

    div_req_t req_reg, req_next;
    div_rsp_t rsp;

    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [PERIOD_W-1:0] freq_reg, freq_next;
    logic [PERIOD_W-1:0] rpm_reg, rpm_next;
    logic                zero_reg, zero_next;
    logic [15:0]         div_eff;
    logic [39:0]         product;

    // A divisor of zero acts as one.
    assign div_eff = (freq_div_reg == '0) ? 16'd1 : freq_div_reg;
    assign product = 40'(freq_reg) * 40'(rpm_scale_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg  <= CLOCK_HZ_RESET;
            freq_div_reg  <= FREQ_DIVISOR_RESET;
            rpm_scale_reg <= RPM_SCALE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CLOCK_HZ:     clock_hz_reg  <= cfg_wdata[31:0];
                CFG_FREQ_DIVISOR: freq_div_reg  <= cfg_wdata[15:0];
                CFG_RPM_SCALE:    rpm_scale_reg <= cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        state_next       = state_reg;
        req_next         = req_reg;
        req_next.start   = 1'b0;
        period_next      = period_reg;
        freq_next        = freq_reg;
        rpm_next         = rpm_reg;
        zero_next        = zero_reg;
        queue_pop        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!queue_empty) begin
                    queue_pop   = 1'b1;
                    period_next = queue_head;
                    if (queue_head == '0) begin
                        freq_next  = '0;
                        rpm_next   = '0;
                        zero_next  = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        zero_next         = 1'b0;
                        req_next.start    = 1'b1;
                        req_next.dividend = clock_hz_reg;
                        req_next.divisor  = queue_head;
                        state_next        = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                if (rsp.done) begin
                    req_next.start    = 1'b1;
                    req_next.dividend = rsp.quotient;
                    req_next.divisor  = PERIOD_W'(div_eff);
                    state_next        = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (rsp.done) begin
                    freq_next  = rsp.quotient;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                rpm_next   = product[PERIOD_W-1:0];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            req_reg   <= '0;
        end else begin
            state_reg <= state_next;
            req_reg   <= req_next;
        end
    end

    always_ff @(posedge aclk) begin
        period_reg <= period_next;
        freq_reg   <= freq_next;
        rpm_reg    <= rpm_next;
        zero_reg   <= zero_next;
    end

    pcrm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .rsp     (rsp)
    );

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {rpm_reg, freq_reg, period_reg};
    assign m_tuser  = zero_reg;

endmodule

FILE: hw/rtl/period_capture_rpm_meter.sv
// ----------------------------------------------------------------------------
// period_capture_rpm_meter
// Measures a signal period from timer events and reports frequency and rpm.
// ----------------------------------------------------------------------------
// Flow: each pair-closing edge's period is written into the queue, popped by the back,
//   divided by two passes of the divider, then multiplied; a zero period
//   skips the divisions and the multiply and goes straight to the output.
// Throughput: the back evaluates one period at a time on the shared bit-serial
//   divider; ticks and first edges are taken every cycle while the queue has room.
// Reset: synchronous, active low; clears edge phase, overflow count, queue and
//   restores clock_hz 168000000, freq_divisor 100, rpm_scale 20.
module period_capture_rpm_meter
    import pcrm_pkg::*;
#(
    parameter int unsigned COUNTER_WIDTH  = 16,
    parameter int unsigned OVERFLOW_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Timer events
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,  // [15:0] capture_value
    input  logic                  s_tuser,  // [0] action (0 overflow tick, 1 edge capture)
    // Measurements
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata,  // [31:0] period_ticks, [63:32] frequency,
                                            // [95:64] rpm
    output logic                  m_tuser   // [0] zero_period
);

    period_item_t        push;
    logic                queue_full;
    logic                queue_empty;
    logic                queue_pop;
    logic [PERIOD_W-1:0] queue_head;

    // Front: track the edge phase, count overflows, form the period and
    // hand it over on each edge that closes a pair.
    pcrm_front #(
        .COUNTER_WIDTH  (COUNTER_WIDTH),
        .OVERFLOW_WIDTH (OVERFLOW_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push)
    );

    // Queue: decouple event intake from the slow arithmetic.
    pcrm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (queue_full),
        .pop     (queue_pop),
        .empty   (queue_empty),
        .head    (queue_head)
    );

    // Back: divide twice and scale a nonzero period, hold the result until taken.
    pcrm_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .queue_empty (queue_empty),
        .queue_head  (queue_head),
        .queue_pop   (queue_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

FILE: hw/rtl/pcrm_checker.sv
// ----------------------------------------------------------------------------
// pcrm_checker
// Port-level checks of the period capture rpm meter, bound to the top level.
// ----------------------------------------------------------------------------
`include "period_capture_rpm_meter_macros.svh"

module pcrm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tuser
);

    // Hold a stalled result.
    `PCRM_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // No result right after reset.
    `PCRM_ASSERT_NXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid)

    // A zero period carries all-zero fields.
    `PCRM_ASSERT_IMP(a_zero_fields, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 96'd0)

    // A flagged-clear result always has a nonzero period.
    `PCRM_ASSERT_IMP(a_nonzero_period, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[31:0] != 32'd0)

endmodule

bind period_capture_rpm_meter pcrm_checker u_pcrm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/sv/period_capture_rpm_meter_tb.sv
// ----------------------------------------------------------------------------
// period_capture_rpm_meter_tb
// Drives timer overflow ticks and edge captures into the rpm meter, predicts
// period, frequency and rpm for each edge pair, and compares every
// measurement that comes out. It steps through several register settings.
// ----------------------------------------------------------------------------
module period_capture_rpm_meter_tb
    import pcrm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Index past the register list; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Saturated overflow count.
    localparam logic [15:0] OVERFLOW_MAX = 16'hFFFF;

    // Cycles to let pass after the last measurement before touching registers
    // or ending the run; covers the divider latency with room to spare.
    localparam int unsigned SETTLE_CYCLES = 200;

    // Random items per register setting.
    localparam int unsigned PHASE_EVENTS = 200;

    typedef enum bit {
        EV_OVERFLOW = 1'b0,
        EV_CAPTURE  = 1'b1
    } timer_event_t;

    typedef struct {
        logic [31:0] period_ticks;
        logic [31:0] frequency;
        logic [31:0] rpm;
        logic        zero_period;
    } meter_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow of the edge phase, overflow count and registers,
    // plus the measurements still owed by the block.
    // ------------------------------------------------------------------------
    class meter_scoreboard;
        bit            armed;
        logic [15:0]   first_edge;
        logic [15:0]   overflow_ticks;
        logic [31:0]   clock_hz;
        logic [15:0]   freq_divisor;
        logic [7:0]    rpm_scale;
        meter_result_t owed_measurements[$];
        int unsigned   errors;
        int unsigned   measured;
        int unsigned   zero_periods;

        function new();
            armed          = 1'b0;
            first_edge     = '0;
            overflow_ticks = '0;
            clock_hz       = CLOCK_HZ_RESET;
            freq_divisor   = FREQ_DIVISOR_RESET;
            rpm_scale      = RPM_SCALE_RESET;
            errors         = 0;
            measured       = 0;
            zero_periods   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                CFG_CLOCK_HZ:     clock_hz     = value;
                CFG_FREQ_DIVISOR: freq_divisor = value[15:0];
                CFG_RPM_SCALE:    rpm_scale    = value[7:0];
                default:          ;
            endcase
        endfunction

        // Predict the measurement for an edge that closes a pair and queue it.
        function void predict_measurement(logic [15:0] second_edge);
            meter_result_t m;
            logic [31:0]   period;
            logic [31:0]   divisor;
            period = {overflow_ticks, 16'h0000} + {16'h0000, second_edge}
                     - {16'h0000, first_edge};
            if (period == 32'd0) begin
                m.period_ticks = '0;
                m.frequency    = '0;
                m.rpm          = '0;
                m.zero_period  = 1'b1;
            end else begin
                divisor        = (freq_divisor == 16'd0) ? 32'd1 : {16'h0000, freq_divisor};
                m.period_ticks = period;
                m.frequency    = (clock_hz / period) / divisor;
                m.rpm          = m.frequency * {24'h000000, rpm_scale};
                m.zero_period  = 1'b0;
            end
            owed_measurements.push_back(m);
        endfunction

        // Note one accepted timer event.
        function void note_event(timer_event_t kind, logic [15:0] cap);
            if (kind == EV_OVERFLOW) begin
                // Ticks only count while a pair is open, and hold at max.
                if (armed && overflow_ticks != OVERFLOW_MAX)
                    overflow_ticks = overflow_ticks + 16'd1;
            end else if (!armed) begin
                first_edge     = cap;
                overflow_ticks = '0;
                armed          = 1'b1;
            end else begin
                predict_measurement(cap);
                armed          = 1'b0;
                overflow_ticks = '0;
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH %s", $realtime, msg);
            errors++;
        endtask

        task check_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s: got 0x%08h, want 0x%08h", field, got, want));
        endtask

        // Compare one accepted measurement with the oldest prediction.
        task check_result(logic [95:0] data, logic zero_flag);
            meter_result_t want;
            if (owed_measurements.size() == 0) begin
                report_mismatch($sformatf("unexpected measurement 0x%024h zero=%0b",
                                          data, zero_flag));
            end else begin
                want = owed_measurements.pop_front();
                measured++;
                if (want.zero_period)
                    zero_periods++;
                check_field("period_ticks", data[31:0], want.period_ticks);
                check_field("frequency", data[63:32], want.frequency);
                check_field("rpm", data[95:64], want.rpm);
                check_field("zero_period", {31'd0, zero_flag}, {31'd0, want.zero_period});
            end
        endtask

        task report_leftovers();
            meter_result_t m;
            while (owed_measurements.size() != 0) begin
                m = owed_measurements.pop_front();
                report_mismatch($sformatf("measurement never came: period 0x%08h",
                                          m.period_ticks));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;  // [15:0] capture_value
    logic                  s_tuser   = 1'b0; // [0] action
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [95:0]           m_tdata;          // [31:0] period, [63:32] freq, [95:64] rpm
    logic                  m_tuser;          // [0] zero_period

    meter_scoreboard sb = new();

    // Idle pattern state: quiet stretches turn all gaps off for a while.
    bit          send_quiet = 1'b0;
    bit          recv_quiet = 1'b0;
    int unsigned events_sent = 0;
    int unsigned settings_run = 1;

    always #5 aclk = ~aclk;

    period_capture_rpm_meter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Write one register; only called while no measurement is owed.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // Offer one timer event and hold it until the block takes it.
    task automatic send_event(timer_event_t kind, logic [15:0] cap);
        int unsigned gap;
        gap = send_quiet ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 39) == 0)
            send_quiet = !send_quiet;
        // Lower valid only when a gap follows, so a back-to-back item keeps
        // valid high without a second assignment in this step.
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        // Ticks carry junk data; the block must ignore it.
        s_tdata  <= (kind == EV_CAPTURE) ? cap : 16'($urandom);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // Ticks before a first edge are dropped by the block; skip them in the count.
        if (kind == EV_CAPTURE || sb.armed)
            events_sent++;
        sb.note_event(kind, cap);
    endtask

    // One edge pair with a number of overflow ticks between the edges.
    task automatic measure(logic [15:0] first, int unsigned ticks, logic [15:0] second);
        send_event(EV_CAPTURE, first);
        repeat (ticks) send_event(EV_OVERFLOW, 16'($urandom));
        send_event(EV_CAPTURE, second);
    endtask

    // Hold the sender until every owed measurement has come back.
    task automatic wait_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_measurements.size() != 0) @(posedge aclk);
    endtask

    // Drain and let the divider finish whatever it may still hold.
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all registers; upper data bits beyond each width are junk and
    // must be masked off, and the spare index must be ignored.
    task automatic apply_setting(logic [31:0] clk_hz, logic [15:0] div, logic [7:0] scale);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(CFG_CLOCK_HZ, clk_hz);
        write_reg(CFG_FREQ_DIVISOR, {junk[31:16], div});
        write_reg(CFG_RPM_SCALE, {junk[23:0], scale});
        write_reg(CFG_SPARE, $urandom);
        settings_run++;
    endtask

    // Mostly well-formed edge pairs with random content; the rest is loose
    // ticks and lone edges that shift the edge phase.
    task automatic random_sequence();
        logic [15:0] first;
        logic [15:0] second;
        int unsigned pick;
        int unsigned ticks;
        pick  = $urandom_range(0, 99);
        first = 16'($urandom);
        if (pick < 50)
            ticks = 0;
        else if (pick < 75)
            ticks = $urandom_range(1, 4);
        else
            ticks = $urandom_range(5, 40);
        // Near edges give short periods and large frequencies.
        second = ($urandom_range(0, 1) == 0) ? first + 16'($urandom_range(0, 64))
                                             : 16'($urandom);
        if ($urandom_range(0, 15) == 0) begin
            second = first;
            ticks  = 0;
        end
        if ($urandom_range(0, 99) < 85)
            measure(first, ticks, second);
        else if ($urandom_range(0, 1) == 0)
            send_event(EV_OVERFLOW, 16'($urandom));
        else
            send_event(EV_CAPTURE, first);
        // Now and then pause the sender until the block has caught up.
        if ($urandom_range(0, 149) == 0)
            wait_results();
    endtask

    task automatic run_phase();
        int unsigned start;
        start = events_sent;
        // A short and a wrapped period first: period 1 drives frequency and rpm to the top.
        measure(16'h0100, 0, 16'h0101);
        measure(16'hFFFF, 0, 16'h0000);
        while (events_sent - start < PHASE_EVENTS)
            random_sequence();
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, accept and check every measurement.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = recv_quiet ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 39) == 0)
                recv_quiet = !recv_quiet;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] rand_clk;
        logic [15:0] rand_div;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed checks on the reset register values.
        send_event(EV_OVERFLOW, 16'hFFFF);       // tick before any edge: dropped
        measure(16'h0000, 0, 16'hFFFF);          // full counter span
        measure(16'hFFFF, 2, 16'h0000);          // ticks plus backward edge values
        measure(16'h1234, 0, 16'h1234);          // zero period
        measure(16'h8000, 0, 16'h0001);          // second below first: period wraps
        measure(16'h0005, 0, 16'h0006);          // period of one tick
        measure(16'h00FF, 1, 16'h00FF);          // exactly one overflow
        wait_results();

        // Random traffic on reset values, then on extreme and random settings.
        run_phase();
        settle();
        apply_setting(32'd1, 16'd1, 8'd1);
        run_phase();
        settle();
        apply_setting(32'hFFFF_FFFF, 16'd0, 8'd255);   // divisor zero acts as one
        run_phase();
        settle();
        apply_setting(32'hFFFF_FFFF, 16'hFFFF, 8'd0);
        run_phase();
        settle();
        apply_setting(32'd0, 16'd7, 8'd3);              // zero clock gives zero frequency
        run_phase();
        repeat (2) begin
            settle();
            rand_clk = $urandom;
            rand_div = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 500));
            apply_setting(rand_clk, rand_div, 8'($urandom));
            run_phase();
        end

        settle();
        sb.report_leftovers();
        $display("Covered %0d timer events and %0d measurements (%0d with zero period)",
                 events_sent, sb.measured, sb.zero_periods);
        $display("over %0d register settings, with random stalls on both sides",
                 settings_run);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #20ms;
        $display("Timeout: run did not reach its end");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/pcrm_pkg.sv
hw/rtl/pcrm_queue.sv
hw/rtl/pcrm_div.sv
hw/rtl/pcrm_front.sv
hw/rtl/pcrm_back.sv
hw/rtl/period_capture_rpm_meter.sv
hw/rtl/pcrm_checker.sv
tb/sv/period_capture_rpm_meter_tb.sv
